// ===== design/aligned_stack_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the aligned stack allocator
// Concurrent property wrappers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_STACK_ALLOCATOR_CORE_ASSERT_SVH
`define ALIGNED_STACK_ALLOCATOR_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define ASA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aligned stack allocator assertion failed");

// Check a consequent in the cycle after its antecedent
`define ASA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aligned stack allocator assertion failed");

`endif

// ===== design/asa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned stack allocator package
// Shared constants, field types, operation and status codes.
// ----------------------------------------------------------------------------
package asa_pkg;

    // Region and stack sizing
    localparam int ADDR_BITS    = 16;
    localparam int STACK_DEPTH  = 64;
    localparam int HEADER_BYTES = 16;

    // Field types
    typedef logic [2:0]  t_mode_bits;
    typedef logic [16:0] t_size;
    typedef logic [3:0]  t_align;
    typedef logic [15:0] t_offset;
    typedef logic [6:0]  t_depth;

    // Largest addressable region and capacity after reset
    localparam t_size ADDR_LIMIT    = t_size'(1) << ADDR_BITS;
    localparam t_size CAPACITY_INIT = 17'h10000;

    // Operation codes
    typedef enum logic [2:0] {
        MODE_ALLOC       = 3'd0,
        MODE_FREE        = 3'd1,
        MODE_REALLOC     = 3'd2,
        MODE_CLEAR       = 3'd3,
        MODE_READ_MARKER = 3'd4,
        MODE_RESTORE     = 3'd5
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_TOP  = 2'd2
    } t_status;

    // One block stack entry: data offset and recorded size
    typedef struct packed {
        t_offset offset;
        t_size   size;
    } t_entry;

endpackage

// ===== design/asa_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned stack allocator request channel
// Valid/ready channel carrying one allocator request.
// ----------------------------------------------------------------------------
interface asa_req_if;
    logic                  valid;
    logic                  ready;
    asa_pkg::t_mode_bits   mode;
    asa_pkg::t_size        size;
    asa_pkg::t_align       align_log2;
    logic                  has_block;
    asa_pkg::t_offset      block_offset;
    asa_pkg::t_size        marker_used;
    asa_pkg::t_depth       marker_depth;

    modport source (
        output valid, mode, size, align_log2, has_block, block_offset,
               marker_used, marker_depth,
        input  ready
    );

    modport sink (
        input  valid, mode, size, align_log2, has_block, block_offset,
               marker_used, marker_depth,
        output ready
    );
endinterface

// ===== design/asa_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned stack allocator response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface asa_rsp_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    asa_pkg::t_offset      result_offset;
    asa_pkg::t_size        used_bytes_out;
    asa_pkg::t_depth       depth_out;

    modport source (
        output valid, status, result_offset, used_bytes_out, depth_out,
        input  ready
    );

    modport sink (
        input  valid, status, result_offset, used_bytes_out, depth_out,
        output ready
    );
endinterface

// ===== design/asa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module asa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/aligned_stack_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned stack allocator core
// LIFO bump allocator: allocate, free, reallocate, clear and marker requests
// over a scratch region of byte offsets, with a block stack held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_req (valid/ready), one result per request leaves on
//   o_rsp (valid/ready). i_cfg_we writes the capacity register; write it only
//   while no request is in flight.
//   A request is taken into an input register, executed against the used
//   count, depth and a cached top-of-stack entry, and its result is held in
//   the result register. One request completes per cycle for every operation
//   while the receiver does not stall.
//   Free and restore pop or move the stack top; the new top entry is read
//   from the stack RAM in the same cycle and forwarded from its registered
//   read port to the next request, so no bubble is added.
//   Reset empties the stack, zeroes the used count and sets the capacity to
//   64 KiB. Stack RAM contents are not cleared.
//   When the receiver stalls, the result register holds, the input register
//   still takes one more request, and i_req.ready then drops.
// ----------------------------------------------------------------------------
module aligned_stack_allocator_core #(
    parameter int STACK_DEPTH  = asa_pkg::STACK_DEPTH,
    parameter int HEADER_BYTES = asa_pkg::HEADER_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    asa_req_if.sink        i_req,
    asa_rsp_if.source      o_rsp,
    input  logic           i_cfg_we,
    input  asa_pkg::t_size i_cfg_wdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_FULL = CW'(STACK_DEPTH);

    // Input register
    logic                r_in_valid;
    asa_pkg::t_mode_bits r_in_mode;
    asa_pkg::t_size      r_in_size;
    asa_pkg::t_align     r_in_align;
    logic                r_in_has;
    asa_pkg::t_offset    r_in_off;
    asa_pkg::t_size      r_in_mused;
    asa_pkg::t_depth     r_in_mdepth;

    // Allocator state
    asa_pkg::t_size      r_capacity;
    asa_pkg::t_size      r_used;
    logic [CW-1:0]       r_count;
    asa_pkg::t_entry     r_top;
    logic                r_use_rd;

    // Result register
    logic                r_out_valid;
    asa_pkg::t_status    r_out_status;
    asa_pkg::t_offset    r_out_offset;
    asa_pkg::t_size      r_out_used;
    asa_pkg::t_depth     r_out_depth;

    // Next values and RAM controls
    asa_pkg::t_size      n_used;
    logic [CW-1:0]       n_count;
    asa_pkg::t_entry     n_top;
    logic                n_use_rd;
    asa_pkg::t_status    n_status;
    asa_pkg::t_offset    n_result;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    asa_pkg::t_entry     ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    asa_pkg::t_entry     ram_rdata;

    // Datapath
    logic                exec_fire;
    logic                in_xfer;
    asa_pkg::t_entry     top_eff;
    asa_pkg::t_size      eff_cap;
    logic [17:0]         align_mask;
    logic [17:0]         aligned;
    logic [18:0]         end_sum;
    logic                alloc_ok;
    asa_pkg::t_size      alloc_rec;
    logic                is_top;
    logic [17:0]         grow_sum;
    logic [17:0]         grow_used;
    logic                grow_fail;
    logic [CW-1:0]       pop_count;

    assign exec_fire   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || exec_fire;
    assign in_xfer     = i_req.valid && i_req.ready;

    // Forward the freshly read top entry until it is cached
    assign top_eff = r_use_rd ? ram_rdata : r_top;
    assign eff_cap = (r_capacity > asa_pkg::ADDR_LIMIT) ? asa_pkg::ADDR_LIMIT : r_capacity;

    // Allocation: skip the header, round up to the alignment, check the fit
    always_comb begin
        align_mask = (18'd1 << r_in_align) - 18'd1;
        aligned    = (18'(r_used) + 18'(HEADER_BYTES) + align_mask) & ~align_mask;
        end_sum    = 19'(aligned) + 19'(r_in_size);
        alloc_ok   = (r_count < DEPTH_FULL) && (end_sum <= 19'(eff_cap)) &&
                     (aligned < 18'(asa_pkg::ADDR_LIMIT));
        alloc_rec  = 17'(aligned - 18'(r_used) + 18'(r_in_size));
    end

    // In-place resize of the top block
    always_comb begin
        is_top    = r_in_has && (r_count != '0) && (top_eff.offset == r_in_off);
        grow_sum  = 18'(r_used) + 18'(r_in_size);
        grow_used = grow_sum - 18'(top_eff.size);
        grow_fail = (grow_sum < 18'(top_eff.size)) || (grow_used > 18'(eff_cap));
        pop_count = r_count - CW'(1);
    end

    // Execute one request
    always_comb begin
        n_used    = r_used;
        n_count   = r_count;
        n_top     = top_eff;
        n_use_rd  = 1'b0;
        n_status  = asa_pkg::ST_OK;
        n_result  = '0;
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = '{offset: aligned[15:0], size: alloc_rec};
        ram_re    = 1'b0;
        ram_raddr = pop_count[AW-1:0];

        unique case (asa_pkg::t_mode'(r_in_mode)) inside
            asa_pkg::MODE_ALLOC, asa_pkg::MODE_REALLOC: begin
                if ((asa_pkg::t_mode'(r_in_mode) == asa_pkg::MODE_REALLOC) && is_top) begin
                    if (grow_fail) begin
                        n_status = asa_pkg::ST_NO_SPACE;
                    end else begin
                        n_used    = 17'(grow_used);
                        n_top     = '{offset: top_eff.offset, size: r_in_size};
                        n_result  = r_in_off;
                        ram_we    = exec_fire;
                        ram_waddr = pop_count[AW-1:0];
                        ram_wdata = '{offset: top_eff.offset, size: r_in_size};
                    end
                end else if (alloc_ok) begin
                    n_used   = 17'(end_sum);
                    n_count  = r_count + CW'(1);
                    n_top    = '{offset: aligned[15:0], size: alloc_rec};
                    n_result = aligned[15:0];
                    ram_we   = exec_fire;
                end else begin
                    n_status = asa_pkg::ST_NO_SPACE;
                end
            end
            asa_pkg::MODE_FREE: begin
                if (is_top) begin
                    n_used   = 17'(r_in_off);
                    n_count  = pop_count;
                    n_use_rd = 1'b1;
                    // Fetch the entry below the popped one
                    ram_raddr = AW'(pop_count - CW'(1));
                    ram_re    = exec_fire && (pop_count != '0);
                end else begin
                    n_status = asa_pkg::ST_NOT_TOP;
                end
            end
            asa_pkg::MODE_CLEAR: begin
                n_used  = '0;
                n_count = '0;
            end
            asa_pkg::MODE_READ_MARKER: begin
                n_used = r_used;
            end
            asa_pkg::MODE_RESTORE: begin
                n_used   = (r_in_mused < eff_cap) ? r_in_mused : eff_cap;
                n_count  = (32'(r_in_mdepth) > STACK_DEPTH) ? DEPTH_FULL : CW'(r_in_mdepth);
                n_use_rd = 1'b1;
                // Fetch the new top entry
                ram_raddr = AW'(n_count - CW'(1));
                ram_re    = exec_fire && (n_count != '0);
            end
            default: begin
                n_used = r_used;
            end
        endcase
    end

    // Block stack storage
    asa_ram #(
        .WIDTH ($bits(asa_pkg::t_entry)),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Capture requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (exec_fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_in_mode   <= i_req.mode;
            r_in_size   <= i_req.size;
            r_in_align  <= i_req.align_log2;
            r_in_has    <= i_req.has_block;
            r_in_off    <= i_req.block_offset;
            r_in_mused  <= i_req.marker_used;
            r_in_mdepth <= i_req.marker_depth;
        end
    end

    // Update allocator state and the cached top entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= asa_pkg::CAPACITY_INIT;
            r_used     <= '0;
            r_count    <= '0;
            r_use_rd   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (exec_fire) begin
                r_used   <= n_used;
                r_count  <= n_count;
                r_use_rd <= n_use_rd;
            end else if (r_use_rd) begin
                r_use_rd <= 1'b0;
            end
        end
        if (exec_fire) begin
            r_top <= n_top;
        end else if (r_use_rd) begin
            r_top <= ram_rdata;
        end
    end

    // Hold results until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (exec_fire) begin
            r_out_status <= n_status;
            r_out_offset <= n_result;
            r_out_used   <= n_used;
            r_out_depth  <= asa_pkg::t_depth'(n_count);
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.result_offset  = r_out_offset;
    assign o_rsp.used_bytes_out = r_out_used;
    assign o_rsp.depth_out      = r_out_depth;

endmodule

// ===== design/asa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned stack allocator port checker
// Watches the result channel of the core over time.
// ----------------------------------------------------------------------------
`include "aligned_stack_allocator_core_assert.svh"

module asa_checker #(
    parameter int STACK_DEPTH = asa_pkg::STACK_DEPTH
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [1:0]       i_rsp_status,
    input asa_pkg::t_offset i_rsp_offset,
    input asa_pkg::t_size   i_rsp_used,
    input asa_pkg::t_depth  i_rsp_depth
);

    logic [41:0] rsp_payload;
    logic        rsp_stall;
    logic        rsp_failed;
    logic        rsp_in_range;

    assign rsp_payload  = {i_rsp_status, i_rsp_offset, i_rsp_used, i_rsp_depth};
    assign rsp_stall    = i_rsp_valid && !i_rsp_ready;
    assign rsp_failed   = i_rsp_valid && (i_rsp_status != 2'(asa_pkg::ST_OK));
    assign rsp_in_range = (32'(i_rsp_depth) <= STACK_DEPTH) &&
                          (i_rsp_used <= asa_pkg::ADDR_LIMIT);

    // Stalled result stays put
    `ASA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, i_rsp_valid && $stable(rsp_payload))
    // No status code outside the defined set
    `ASA_ASSERT_SAME(a_status_code, i_clk, i_rst_n, i_rsp_valid, i_rsp_status != 2'd3)
    // Failed requests report no block
    `ASA_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, rsp_failed, i_rsp_offset == '0)
    // Reported depth and used count stay within the stack and region
    `ASA_ASSERT_SAME(a_state_range, i_clk, i_rst_n, i_rsp_valid, rsp_in_range)

endmodule

bind aligned_stack_allocator_core asa_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_asa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_offset (o_rsp.result_offset),
    .i_rsp_used   (o_rsp.used_bytes_out),
    .i_rsp_depth  (o_rsp.depth_out)
);

// ===== tb/aligned_stack_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned stack allocator core testbench
// Drives allocate, free, reallocate, clear and marker requests through the
// valid/ready channels under random idling and long reply hold-offs. It also
// steps the capacity register through several values, extremes included. A
// self-contained model of the block stack predicts each reply, and every
// reply is compared field by field in arrival order.
// ----------------------------------------------------------------------------

typedef struct {
    asa_pkg::t_mode_bits mode;
    asa_pkg::t_size      size;
    asa_pkg::t_align     align_log2;
    logic                has_block;
    asa_pkg::t_offset    block_offset;
    asa_pkg::t_size      marker_used;
    asa_pkg::t_depth     marker_depth;
} t_alloc_request;

typedef struct {
    logic [1:0]          status;
    asa_pkg::t_offset    result_offset;
    asa_pkg::t_size      used_bytes_out;
    asa_pkg::t_depth     depth_out;
} t_alloc_reply;

// Mode codes outside the operation set; the block must treat them as no-ops
localparam asa_pkg::t_mode_bits MODE_SPARE_LO = 3'd6;
localparam asa_pkg::t_mode_bits MODE_SPARE_HI = 3'd7;

class stack_ledger;
    asa_pkg::t_size   capacity;
    asa_pkg::t_size   used;
    int unsigned      depth;
    int unsigned      filled_depth;   // entries 0..filled_depth-1 have been written
    asa_pkg::t_offset offsets [asa_pkg::STACK_DEPTH];
    asa_pkg::t_size   sizes [asa_pkg::STACK_DEPTH];
    t_alloc_reply     due_replies [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      ok_seen;
    int unsigned      no_space_seen;
    int unsigned      not_top_seen;

    function new();
        capacity      = asa_pkg::CAPACITY_INIT;
        used          = '0;
        depth         = 0;
        filled_depth  = 0;
        mismatches    = 0;
        checked       = 0;
        ok_seen       = 0;
        no_space_seen = 0;
        not_top_seen  = 0;
    endfunction

    function logic [31:0] usable_bytes();
        return (capacity < asa_pkg::ADDR_LIMIT) ? 32'(capacity) : 32'(asa_pkg::ADDR_LIMIT);
    endfunction

    function int unsigned top_offset();
        return (depth > 0) ? 32'(offsets[depth - 1]) : 32'd0;
    endfunction

    // Push a new block if it fits; report its data offset
    function bit push_block(asa_pkg::t_size req_size, asa_pkg::t_align alog,
                            output asa_pkg::t_offset where);
        logic [31:0] align_bytes;
        logic [31:0] aligned;
        align_bytes = 32'd1 << alog;
        aligned     = (32'(used) + 32'(asa_pkg::HEADER_BYTES) + align_bytes - 32'd1) &
                      ~(align_bytes - 32'd1);
        where       = '0;
        if (depth >= asa_pkg::STACK_DEPTH || aligned + 32'(req_size) > usable_bytes() ||
            aligned >= (32'd1 << asa_pkg::ADDR_BITS)) begin
            return 1'b0;
        end
        offsets[depth] = aligned[15:0];
        sizes[depth]   = asa_pkg::t_size'(aligned - 32'(used) + 32'(req_size));
        if (depth == filled_depth) begin
            filled_depth++;
        end
        depth++;
        used  = asa_pkg::t_size'(aligned + 32'(req_size));
        where = aligned[15:0];
        return 1'b1;
    endfunction

    // Advance the model by one accepted request and queue its reply
    function void apply_request(t_alloc_request r);
        t_alloc_reply     e;
        asa_pkg::t_offset where;
        logic [31:0]      grown;
        logic [31:0]      prior_size;
        bit               on_top;
        e.status        = asa_pkg::ST_OK;
        e.result_offset = '0;
        on_top = r.has_block && depth > 0 && offsets[depth - 1] == r.block_offset;
        case (r.mode)
            asa_pkg::MODE_ALLOC: begin
                if (push_block(r.size, r.align_log2, where)) e.result_offset = where;
                else e.status = asa_pkg::ST_NO_SPACE;
            end
            asa_pkg::MODE_FREE: begin
                if (on_top) begin
                    used = asa_pkg::t_size'(r.block_offset);
                    depth--;
                end else begin
                    e.status = asa_pkg::ST_NOT_TOP;
                end
            end
            asa_pkg::MODE_REALLOC: begin
                if (on_top) begin
                    grown      = 32'(used) + 32'(r.size);
                    prior_size = 32'(sizes[depth - 1]);
                    if (grown < prior_size || grown - prior_size > usable_bytes()) begin
                        e.status = asa_pkg::ST_NO_SPACE;
                    end else begin
                        used              = asa_pkg::t_size'(grown - prior_size);
                        sizes[depth - 1]  = r.size;
                        e.result_offset   = r.block_offset;
                    end
                end else if (push_block(r.size, r.align_log2, where)) begin
                    e.result_offset = where;
                end else begin
                    e.status = asa_pkg::ST_NO_SPACE;
                end
            end
            asa_pkg::MODE_CLEAR: begin
                used  = '0;
                depth = 0;
            end
            asa_pkg::MODE_RESTORE: begin
                used  = (32'(r.marker_used) < usable_bytes()) ? r.marker_used
                                                              : asa_pkg::t_size'(usable_bytes());
                depth = (32'(r.marker_depth) < asa_pkg::STACK_DEPTH) ? 32'(r.marker_depth)
                                                                     : asa_pkg::STACK_DEPTH;
            end
            default: begin
            end
        endcase
        e.used_bytes_out = used;
        e.depth_out      = asa_pkg::t_depth'(depth);
        due_replies.push_back(e);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // Match one reply against the oldest outstanding prediction
    function void check_reply(t_alloc_reply got);
        t_alloc_reply want;
        if (due_replies.size() == 0) begin
            mismatches++;
            $display("%0t: reply with no request outstanding, expected none, actual status %0d",
                     $time, got.status);
            return;
        end
        want = due_replies.pop_front();
        checked++;
        case (want.status)
            asa_pkg::ST_OK:       ok_seen++;
            asa_pkg::ST_NO_SPACE: no_space_seen++;
            default:              not_top_seen++;
        endcase
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("result_offset", 32'(want.result_offset), 32'(got.result_offset));
        compare_field("used_bytes_out", 32'(want.used_bytes_out), 32'(got.used_bytes_out));
        compare_field("depth_out", 32'(want.depth_out), 32'(got.depth_out));
    endfunction
endclass

module aligned_stack_allocator_core_tb;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_we;
    asa_pkg::t_size  i_cfg_wdata;

    asa_req_if       req_if ();
    asa_rsp_if       rsp_if ();

    stack_ledger     ledger;
    bit              idle_on = 1'b1;
    int unsigned     rsp_hold_cycles = 0;
    int unsigned     sent_count = 0;
    asa_pkg::t_size  saved_used = '0;
    asa_pkg::t_depth saved_depth = '0;

    aligned_stack_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_alloc_request make_request(asa_pkg::t_mode_bits mode,
                                                    int unsigned size, int unsigned alog,
                                                    int unsigned has_block,
                                                    int unsigned block_offset,
                                                    int unsigned mused, int unsigned mdepth);
        t_alloc_request r;
        r.mode         = mode;
        r.size         = asa_pkg::t_size'(size);
        r.align_log2   = asa_pkg::t_align'(alog);
        r.has_block    = 1'(has_block);
        r.block_offset = asa_pkg::t_offset'(block_offset);
        r.marker_used  = asa_pkg::t_size'(mused);
        r.marker_depth = asa_pkg::t_depth'(mdepth);
        return r;
    endfunction

    // Mostly well-formed traffic on the live stack top, plus noise
    function automatic t_alloc_request next_random_request();
        t_alloc_request r;
        int unsigned    pick;
        int unsigned    roll;
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        r.mode         = asa_pkg::MODE_ALLOC;
        r.size         = (roll < 80) ? asa_pkg::t_size'($urandom_range(0, 256)) :
                         (roll < 97) ? asa_pkg::t_size'($urandom_range(0, 65535)) :
                                       asa_pkg::t_size'(17'h10000);
        r.align_log2   = ($urandom_range(0, 99) < 80) ? asa_pkg::t_align'($urandom_range(0, 6))
                                                      : asa_pkg::t_align'($urandom_range(0, 15));
        r.has_block    = 1'($urandom_range(0, 1));
        r.block_offset = asa_pkg::t_offset'($urandom_range(0, 65535));
        r.marker_used  = asa_pkg::t_size'($urandom_range(0, 65536));
        r.marker_depth = asa_pkg::t_depth'($urandom_range(0, 64));
        if (pick < 38) begin
            r.mode = asa_pkg::MODE_ALLOC;
        end else if (pick < 56) begin
            r.mode         = asa_pkg::MODE_FREE;
            r.has_block    = 1'b1;
            r.block_offset = asa_pkg::t_offset'(ledger.top_offset());
        end else if (pick < 68) begin
            r.mode         = asa_pkg::MODE_REALLOC;
            r.has_block    = 1'b1;
            r.block_offset = asa_pkg::t_offset'(ledger.top_offset());
            if (roll < 85) r.size = asa_pkg::t_size'($urandom_range(0, 512));
        end else if (pick < 74) begin
            r.mode = asa_pkg::MODE_REALLOC;
        end else if (pick < 80) begin
            r.mode = asa_pkg::MODE_FREE;
        end else if (pick < 83) begin
            r.mode = asa_pkg::MODE_CLEAR;
        end else if (pick < 89) begin
            r.mode      = asa_pkg::MODE_READ_MARKER;
            saved_used  = ledger.used;
            saved_depth = asa_pkg::t_depth'(ledger.depth);
        end else if (pick < 95) begin
            r.mode         = asa_pkg::MODE_RESTORE;
            r.marker_used  = saved_used;
            r.marker_depth = saved_depth;
        end else begin
            // only expose stack entries that hold written data
            r.mode         = asa_pkg::MODE_RESTORE;
            r.marker_depth = asa_pkg::t_depth'($urandom_range(0, ledger.filled_depth));
        end
        return r;
    endfunction

    // Offer one request, hold it until the transfer, then update the model
    task automatic offer_request(input t_alloc_request r);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.mode         <= r.mode;
        req_if.size         <= r.size;
        req_if.align_log2   <= r.align_log2;
        req_if.has_block    <= r.has_block;
        req_if.block_offset <= r.block_offset;
        req_if.marker_used  <= r.marker_used;
        req_if.marker_depth <= r.marker_depth;
        req_if.valid        <= 1'b1;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        ledger.apply_request(r);
        sent_count++;
    endtask

    // Stop offering and wait for every outstanding reply
    task automatic drain_replies();
        req_if.valid <= 1'b0;
        while (ledger.due_replies.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input asa_pkg::t_size value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ledger.capacity = value;
    endtask

    // Reply side: random or long hold-offs, then check each transfer
    initial begin : reply_sink
        t_alloc_reply got;
        int unsigned  stall;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = (rsp_hold_cycles > 0) ? rsp_hold_cycles
                                          : (idle_on ? $urandom_range(0, 4) : 0);
            rsp_hold_cycles = 0;
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
            got.status         = rsp_if.status;
            got.result_offset  = rsp_if.result_offset;
            got.used_bytes_out = rsp_if.used_bytes_out;
            got.depth_out      = rsp_if.depth_out;
            ledger.check_reply(got);
        end
    end

    initial begin : stimulus
        asa_pkg::t_size phase_cap [8];
        int unsigned    phase_items [8];
        asa_pkg::t_size fill_used;
        asa_pkg::t_size cap_value;
        ledger = new();
        phase_cap   = '{17'd0, 17'd1000, 17'h10000, 17'd40000, 17'd65535, 17'd300,
                        17'd0, 17'h10000};
        phase_items = '{40, 200, 240, 200, 200, 150, 200, 170};

        req_if.valid        <= 1'b0;
        req_if.mode         <= asa_pkg::MODE_ALLOC;
        req_if.size         <= '0;
        req_if.align_log2   <= '0;
        req_if.has_block    <= 1'b0;
        req_if.block_offset <= '0;
        req_if.marker_used  <= '0;
        req_if.marker_depth <= '0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        i_rst_n             <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners at the reset capacity
        offer_request(make_request(asa_pkg::MODE_FREE, 0, 0, 1, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_READ_MARKER, 0, 0, 0, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_ALLOC, 0, 0, 0, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_ALLOC, 65536, 15, 0, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_ALLOC, 100, 15, 0, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_REALLOC, 32768, 0, 1,
                                   ledger.top_offset(), 0, 0));
        offer_request(make_request(asa_pkg::MODE_REALLOC, 65536, 0, 1,
                                   ledger.top_offset(), 0, 0));
        offer_request(make_request(asa_pkg::MODE_REALLOC, 0, 0, 1, ledger.top_offset(), 0, 0));
        offer_request(make_request(asa_pkg::MODE_FREE, 0, 0, 1, 16, 0, 0));
        offer_request(make_request(asa_pkg::MODE_FREE, 0, 0, 0, ledger.top_offset(), 0, 0));
        offer_request(make_request(asa_pkg::MODE_REALLOC, 8, 3, 0, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_REALLOC, 4, 1, 1, 16, 0, 0));
        repeat (4) offer_request(make_request(asa_pkg::MODE_FREE, 0, 0, 1,
                                              ledger.top_offset(), 0, 0));
        offer_request(make_request(MODE_SPARE_LO, 65536, 15, 1, 65535, 65536, 64));
        offer_request(make_request(MODE_SPARE_HI, 1, 1, 0, 1, 1, 1));
        offer_request(make_request(asa_pkg::MODE_ALLOC, 65536, 0, 0, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_ALLOC, 65520, 0, 0, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_ALLOC, 0, 0, 0, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_READ_MARKER, 0, 0, 0, 0, 0, 0));
        offer_request(make_request(asa_pkg::MODE_RESTORE, 0, 0, 0, 0, 65536, 1));
        offer_request(make_request(asa_pkg::MODE_RESTORE, 0, 0, 0, 0, 12345, 0));
        offer_request(make_request(asa_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0));

        // Random phases, each under its own capacity setting
        for (int ph = 0; ph < 8; ph++) begin
            drain_replies();
            cap_value = (ph == 6) ? asa_pkg::t_size'($urandom_range(0, 65536)) : phase_cap[ph];
            write_capacity(cap_value);
            idle_on = (ph % 3 != 1);
            if (ph == 2) begin
                // fill the stack past its depth, then expose the full stack again
                offer_request(make_request(asa_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0));
                repeat (asa_pkg::STACK_DEPTH + 2) begin
                    offer_request(make_request(asa_pkg::MODE_ALLOC, $urandom_range(0, 64),
                                               $urandom_range(0, 4), 0, 0, 0, 0));
                end
                fill_used = ledger.used;
                repeat (3) offer_request(make_request(asa_pkg::MODE_FREE, 0, 0, 1,
                                                      ledger.top_offset(), 0, 0));
                offer_request(make_request(asa_pkg::MODE_RESTORE, 0, 0, 0, 0, 32'(fill_used),
                                           asa_pkg::STACK_DEPTH));
            end
            for (int k = 0; k < phase_items[ph]; k++) begin
                if ((ph == 3 && k == 10) || (ph == 6 && k == 50)) begin
                    rsp_hold_cycles = 150;
                end
                offer_request(next_random_request());
            end
        end

        drain_replies();
        repeat (4) @(posedge i_clk);
        $display("summary: %0d requests under 9 capacity settings, %0d replies checked",
                 sent_count, ledger.checked);
        $display("summary: ok %0d, no space %0d, not top %0d, stack entries written %0d",
                 ledger.ok_seen, ledger.no_space_seen, ledger.not_top_seen,
                 ledger.filled_depth);
        if (ledger.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
